### hw/rtl/rmq_pkg.sv
package rmq_pkg;

   typedef struct packed {
      logic               action;
      logic [9:0]         element_index;
      logic signed [31:0] element_value;
      logic [9:0]         range_left;
      logic [9:0]         range_right;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [9:0]         min_index;
      logic signed [31:0] min_value;
   } rsp_type;

   localparam int CountWidth = 11;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_BUILD  = 5'b00010,
      ST_GAP    = 5'b00100,
      ST_QISSUE = 5'b01000,
      ST_QOUT   = 5'b10000
   } state_type;

endpackage

### hw/rtl/rmq_table.sv
module rmq_table #(
   parameter int AW = 14,
   parameter int DW = 42
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr_a,
   input  logic [AW-1:0] rd_addr_b,
   output logic [DW-1:0] rd_data_a,
   output logic [DW-1:0] rd_data_b
);

   logic [DW-1:0] mem [1<<AW];
   logic [DW-1:0] rd_a_ff;
   logic [DW-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### hw/rtl/range_minimum_query.sv
// Range-minimum query over a loaded array of signed Q16.16 values.
//
// Input channel: req word is taken at a clock edge with start high and busy
// low. action LOAD writes element_value at element_index (ignored at
// MAX_ELEMENTS or above) and produces no result. action QUERY
// returns the leftmost position of the smallest value in
// [range_left, range_right] plus that value; an invalid range gives found low.
// Result channel: rsp_valid is high for exactly one cycle with the rsp word;
// the receiver cannot stall, so nothing is ever held back.
// Config: csr_write_enable writes element_count; the user writes it only
// while busy is low, which the block itself does not enforce. A query on
// a current table reads two sparse-table windows, then compares them and
// registers the result. A valid query holds busy until its compare, so the
// next waits; loads and invalid queries go every cycle while busy is low.
// The first valid query after reset or an accepted load rebuilds the
// table level by level from level 1, one entry per cycle through the two
// read ports of the table memory, with a gap state after each level.
// Reset: control clears, table is marked stale; memory contents are kept
// and are not cleared; the rebuild reads every position, loaded or not.
module range_minimum_query #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int TABLE_LEVELS = 11
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  rmq_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   output rmq_pkg::rsp_type                 rsp_data,
   input  logic                             csr_write_enable,
   input  logic [rmq_pkg::CountWidth-1:0]   csr_write_data
);
   import rmq_pkg::*;

   localparam int IW = $clog2(MAX_ELEMENTS);
   localparam int LW = $clog2(TABLE_LEVELS);
   localparam int EW = IW + 32;     // entry: {position, value}
   localparam int AW = LW + IW;     // address: {level, position}

   // leftmost minimum of two entries
   function automatic logic [EW-1:0] pick(input logic [EW-1:0] a, input logic [EW-1:0] b);
      logic signed [31:0] va;
      logic signed [31:0] vb;
      va = a[31:0];
      vb = b[31:0];
      if (va < vb)                     pick = a;
      else if (vb < va)                pick = b;
      else if (a[EW-1:32] <= b[EW-1:32]) pick = a;
      else                             pick = b;
   endfunction

   state_type            state_ff, state_in;
   logic                 stale_ff, stale_in;
   logic [CountWidth-1:0] count_ff;
   logic [LW-1:0]        lvl_ff, lvl_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic                 wr_vld_ff;
   logic [AW-1:0]        wr_addr_ff;
   logic [9:0]           qleft_ff, qright_ff;
   logic                 rsp_vld_ff, rsp_vld_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 accept;
   logic                 q_valid;
   logic [9:0]           q_left, q_right;
   logic [10:0]          q_len;
   logic [LW-1:0]        q_k;
   logic [10:0]          q_b_idx;
   logic [AW-1:0]        rd_addr_a, rd_addr_b;
   logic [EW-1:0]        rd_data_a, rd_data_b;
   logic [EW-1:0]        best;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [EW-1:0]        wr_data;
   logic                 lvl_last_idx;
   logic                 lvl_more;
   logic                 load_ok;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // query source: live word in idle, latched copy after a rebuild
   assign q_left  = (state_ff == ST_IDLE) ? req_data.range_left  : qleft_ff;
   assign q_right = (state_ff == ST_IDLE) ? req_data.range_right : qright_ff;
   assign q_len   = {1'b0, q_right} - {1'b0, q_left} + 11'd1;

   always_comb begin
      q_k = '0;
      for (int b = 0; b < 11; b++) begin
         if (q_len[b]) q_k = LW'(b);
      end
      if (32'(q_k) > TABLE_LEVELS - 1) q_k = LW'(TABLE_LEVELS - 1);
   end

   assign q_b_idx = {1'b0, q_right} + 11'd1 - (11'd1 << q_k);

   assign q_valid = (req_data.range_left <= req_data.range_right) &&
                    ({1'b0, req_data.range_right} < count_ff) &&
                    (32'(req_data.range_right) < MAX_ELEMENTS);

   assign load_ok = (32'(req_data.element_index) < MAX_ELEMENTS);

   assign lvl_last_idx = (32'(idx_ff) == MAX_ELEMENTS - (32'd1 << lvl_ff));
   assign lvl_more     = (32'(lvl_ff) + 1 < TABLE_LEVELS) &&
                         ((32'd1 << (32'(lvl_ff) + 1)) <= MAX_ELEMENTS);

   // read ports: level j-1 pair while building, two windows for a query
   always_comb begin
      if (state_ff == ST_BUILD) begin
         rd_addr_a = {lvl_ff - LW'(1), idx_ff};
         rd_addr_b = {lvl_ff - LW'(1), idx_ff + IW'(32'd1 << (lvl_ff - LW'(1)))};
      end else begin
         rd_addr_a = {q_k, IW'(q_left)};
         rd_addr_b = {q_k, IW'(q_b_idx)};
      end
   end

   assign best = pick(rd_data_a, rd_data_b);

   // write port: level-0 loads in idle, built entries in the cycle after read
   always_comb begin
      if (wr_vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = wr_addr_ff;
         wr_data = best;
      end else begin
         wr_en   = accept && (req_data.action == ACT_LOAD) && load_ok;
         wr_addr = {LW'(0), IW'(req_data.element_index)};
         wr_data = {IW'(req_data.element_index), req_data.element_value};
      end
   end

   rmq_table #(.AW(AW), .DW(EW)) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   always_comb begin
      state_in   = state_ff;
      stale_in   = stale_ff;
      lvl_in     = lvl_ff;
      idx_in     = idx_ff;
      rsp_vld_in = 1'b0;
      rsp_in     = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.action == ACT_LOAD) begin
               if (load_ok) stale_in = 1'b1;
            end else if (accept) begin
               if (!q_valid) begin
                  rsp_vld_in = 1'b1;
                  rsp_in     = '0;
               end else if (stale_ff) begin
                  state_in = ST_BUILD;
                  lvl_in   = LW'(1);
                  idx_in   = '0;
               end else begin
                  state_in = ST_QOUT;
               end
            end
         end
         ST_BUILD: begin
            if (lvl_last_idx) state_in = ST_GAP;
            else              idx_in   = idx_ff + IW'(1);
         end
         ST_GAP: begin
            // last write of the level lands here
            if (lvl_more) begin
               state_in = ST_BUILD;
               lvl_in   = lvl_ff + LW'(1);
               idx_in   = '0;
            end else begin
               stale_in = 1'b0;
               state_in = ST_QISSUE;
            end
         end
         ST_QISSUE: state_in = ST_QOUT;
         ST_QOUT: begin
            rsp_vld_in       = 1'b1;
            rsp_in.found     = 1'b1;
            rsp_in.min_index = 10'(best[EW-1:32]);
            rsp_in.min_value = best[31:0];
            state_in         = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         stale_ff   <= 1'b1;
         count_ff   <= '0;
         wr_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         stale_ff   <= stale_in;
         wr_vld_ff  <= (state_ff == ST_BUILD);
         rsp_vld_ff <= rsp_vld_in;
         if (csr_write_enable) count_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff     <= lvl_in;
      idx_ff     <= idx_in;
      wr_addr_ff <= {lvl_ff, idx_ff};
      rsp_ff     <= rsp_in;
      if (accept) begin
         qleft_ff  <= req_data.range_left;
         qright_ff <= req_data.range_right;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   a_qout_answers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QOUT) |=> (rsp_valid && rsp_data.found))
      else $error("query read did not produce a result");

   a_found_needs_table: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.found) |-> !stale_ff)
      else $error("result given from a stale table");

   a_quiet_in_build: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BUILD) |-> (!rsp_valid && !(wr_vld_ff && accept)))
      else $error("result or load during rebuild");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state not one-hot");

endmodule
